FILE: rtl/core/khash_pkg.sv
// ----------------------------------------------------------------------------
// khash_pkg
// Shared constants, codes and types of the keyed counter hash table.
// ----------------------------------------------------------------------------
package khash_pkg;

  localparam int BUCKETS_LOG2 = 7;
  localparam int BUCKETS      = 1 << BUCKETS_LOG2;
  localparam int WAYS         = 4;
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS        = BUCKETS * WAYS;
  localparam int ROW_AW       = BUCKETS_LOG2;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 2;
  localparam int ENT_W    = 10;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ENT_W-1:0]    ent_t;
  typedef logic [WAY_W-1:0]    way_t;

  localparam func_t OP_INSERT = 2'd0;
  localparam func_t OP_WATCH  = 2'd1;
  localparam func_t OP_REMOVE = 2'd2;
  localparam func_t OP_LOOKUP = 2'd3;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_MISS = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    key_t key;
    tag_t tag;
    cnt_t count;
  } slot_t;

  typedef struct packed {
    logic [WAYS-1:0]  vld;
    slot_t [WAYS-1:0] slot;
  } row_t;

  typedef struct packed {
    func_t func;
    key_t  key;
    tag_t  tag;
    cnt_t  init;
  } req_t;

  typedef struct packed {
    status_t status;
    cnt_t    count;
    tag_t    tag;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic inc;
    logic dec;
  } upd_t;

endpackage

FILE: rtl/core/khash_if.sv
// ----------------------------------------------------------------------------
// khash_req_if / khash_rsp_if
// Valid/ready channels for requests and results of the hash table.
// ----------------------------------------------------------------------------
interface khash_req_if;
  logic                 valid;
  logic                 ready;
  khash_pkg::func_t     func;
  khash_pkg::key_t      key;
  khash_pkg::tag_t      payload_tag;
  khash_pkg::cnt_t      initial_count;

  modport source (output valid, output func, output key, output payload_tag,
                  output initial_count, input ready);
  modport sink (input valid, input func, input key, input payload_tag,
                input initial_count, output ready);
endinterface

interface khash_rsp_if;
  logic                 valid;
  logic                 ready;
  khash_pkg::status_t   status;
  khash_pkg::cnt_t      count_out;
  khash_pkg::tag_t      tag_out;
  khash_pkg::ent_t      entries;

  modport source (output valid, output status, output count_out, output tag_out,
                  output entries, input ready);
  modport sink (input valid, input status, input count_out, input tag_out,
                input entries, output ready);
endinterface

FILE: rtl/core/khash_row_ram.sv
// ----------------------------------------------------------------------------
// khash_row_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module khash_row_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/khash_bucket_logic.sv
// ----------------------------------------------------------------------------
// khash_bucket_logic
// Matches a request against one bucket row and builds the updated row.
// ----------------------------------------------------------------------------
module khash_bucket_logic (
  input  khash_pkg::req_t req_i,
  input  khash_pkg::row_t row_i,
  output khash_pkg::row_t row_o,
  output khash_pkg::rsp_t rsp_o,
  output khash_pkg::upd_t upd_o
);

  logic            hit;
  logic            free;
  khash_pkg::way_t hit_way;
  khash_pkg::way_t free_way;
  khash_pkg::cnt_t cnt_cur;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = khash_pkg::WAYS - 1; w >= 0; w--) begin
      if (row_i.vld[w] && (row_i.slot[w].key == req_i.key)) begin
        hit     = 1'b1;
        hit_way = khash_pkg::WAY_W'(w);
      end
      if (!row_i.vld[w]) begin
        free     = 1'b1;
        free_way = khash_pkg::WAY_W'(w);
      end
    end
  end

  assign cnt_cur = row_i.slot[hit_way].count;

  always_comb begin
    row_o        = row_i;
    rsp_o.status = khash_pkg::ST_DONE;
    rsp_o.count  = '0;
    rsp_o.tag    = '0;
    upd_o        = '0;
    unique case (req_i.func)
      khash_pkg::OP_INSERT: begin
        if (hit) begin
          rsp_o.status = khash_pkg::ST_DUP;
        end else if (!free) begin
          rsp_o.status = khash_pkg::ST_FULL;
        end else begin
          row_o.vld[free_way]        = 1'b1;
          row_o.slot[free_way].key   = req_i.key;
          row_o.slot[free_way].tag   = req_i.tag;
          row_o.slot[free_way].count = req_i.init;
          upd_o.wr  = 1'b1;
          upd_o.inc = 1'b1;
        end
      end
      khash_pkg::OP_WATCH: begin
        if (!hit) begin
          rsp_o.status = khash_pkg::ST_MISS;
        end else begin
          if (cnt_cur != khash_pkg::COUNT_MAX) begin
            row_o.slot[hit_way].count = cnt_cur + khash_pkg::CNT_W'(1);
            upd_o.wr = 1'b1;
          end
          rsp_o.count = row_o.slot[hit_way].count;
          rsp_o.tag   = row_i.slot[hit_way].tag;
        end
      end
      khash_pkg::OP_REMOVE: begin
        if (!hit) begin
          rsp_o.status = khash_pkg::ST_MISS;
        end else begin
          row_o.vld[hit_way] = 1'b0;
          upd_o.wr  = 1'b1;
          upd_o.dec = 1'b1;
        end
      end
      khash_pkg::OP_LOOKUP: begin
        if (!hit) begin
          rsp_o.status = khash_pkg::ST_MISS;
        end else begin
          rsp_o.count = cnt_cur;
          rsp_o.tag   = row_i.slot[hit_way].tag;
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/keyed_counter_hash_table.sv
// ----------------------------------------------------------------------------
// keyed_counter_hash_table
// Bucketed key table with per-entry tag and saturating count, held in one
// row-wide RAM: a request reads its bucket row, then writes it back if it changes.
//
//   channel   port     direction   carries
//   request   in_if    sink        func, key, payload_tag, initial_count
//   result    out_if   source      status, count_out, tag_out, entries
//
// Each request is handled as the bucket row read, then the compare and
// write-back; the next request is taken only after both are done.
// After reset the table clears one row per cycle, all BUCKETS rows (128),
// and accepts no request until the sweep is done.
// A waiting result blocks the next transfer while out_if.ready is low; once
// the result is taken, a new request can be accepted in that same cycle.
// ----------------------------------------------------------------------------
module keyed_counter_hash_table (
  input logic          clk,
  input logic          rst_n,
  khash_req_if.sink    in_if,
  khash_rsp_if.source  out_if
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [khash_pkg::ROW_AW-1:0]   clr_row_r, clr_row_nxt;
  khash_pkg::req_t                req_r;
  khash_pkg::ent_t                ent_r, ent_nxt;
  logic                           out_valid_r, out_valid_nxt;
  khash_pkg::rsp_t                rsp_r;
  khash_pkg::ent_t                rsp_ent_r;

  logic                           in_fire;
  logic                           out_fire;
  logic                           exec;
  khash_pkg::row_t                row_rd;
  khash_pkg::row_t                row_wr;
  khash_pkg::rsp_t                rsp;
  khash_pkg::upd_t                upd;
  logic                           ram_we;
  logic [khash_pkg::ROW_AW-1:0]   ram_waddr;
  khash_pkg::row_t                ram_wdata;

  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_r && out_if.ready;
  assign exec        = (state_r == S_EXEC);

  khash_row_ram #(
    .DEPTH (khash_pkg::BUCKETS),
    .WIDTH ($bits(khash_pkg::row_t))
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_if.key[khash_pkg::ROW_AW-1:0]),
    .rdata (row_rd)
  );

  khash_bucket_logic u_bucket (
    .req_i (req_r),
    .row_i (row_rd),
    .row_o (row_wr),
    .rsp_o (rsp),
    .upd_o (upd)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_r.key[khash_pkg::ROW_AW-1:0];
    ram_wdata = row_wr;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row_r;
      ram_wdata = '0;
    end else if (exec) begin
      ram_we = upd.wr;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r && !out_fire;
    unique case (state_r)
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + khash_pkg::ROW_AW'(1);
        if (clr_row_r == khash_pkg::ROW_AW'(khash_pkg::BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (upd.inc) begin
          ent_nxt = ent_r + khash_pkg::ENT_W'(1);
        end else if (upd.dec) begin
          ent_nxt = ent_r - khash_pkg::ENT_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      ent_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      ent_r       <= ent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.func <= in_if.func;
      req_r.key  <= in_if.key;
      req_r.tag  <= in_if.payload_tag;
      req_r.init <= in_if.initial_count;
    end
    if (exec) begin
      rsp_r     <= rsp;
      rsp_ent_r <= ent_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = rsp_r.status;
  assign out_if.count_out = rsp_r.count;
  assign out_if.tag_out   = rsp_r.tag;
  assign out_if.entries   = rsp_ent_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##2 out_valid_r)
    else $error("accepted request produced no result");

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_r <= khash_pkg::ENT_W'(khash_pkg::SLOTS))
    else $error("entry count beyond table size");

  a_remove_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && upd.dec) |-> (ent_r != '0))
    else $error("remove of an entry while the entry count is zero");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !(upd.inc && upd.dec))
    else $error("insert and remove flagged together");

endmodule

FILE: tb/keyed_counter_hash_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_counter_hash_table_checker
// Watches the request and result channels of the hash table, keeps its own
// copy of the bucket slots and the entry total, predicts the result of every
// accepted request and compares each result transfer with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module keyed_counter_hash_table_checker
  import khash_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  khash_req_if  req,
  khash_rsp_if  rsp,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    status_t status;
    cnt_t    count;
    tag_t    tag;
    ent_t    entries;
  } table_reply_t;

  bit   held       [SLOTS];
  key_t held_key   [SLOTS];
  tag_t held_tag   [SLOTS];
  cnt_t held_count [SLOTS];
  int   held_total;

  table_reply_t expected_replies[$];

  function automatic table_reply_t apply_request(func_t op, key_t key, tag_t tag, cnt_t init);
    int           base;
    int           hit;
    int           free_slot;
    int           w;
    table_reply_t r;
    base = int'(key % BUCKETS) * WAYS;
    hit = -1;
    free_slot = -1;
    for (w = 0; w < WAYS; w++) begin
      if (held[base + w] && held_key[base + w] == key && hit < 0) begin
        hit = base + w;
      end
      if (!held[base + w] && free_slot < 0) begin
        free_slot = base + w;
      end
    end
    r = '0;
    r.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_DUP;
      end else if (free_slot < 0) begin
        r.status = ST_FULL;
      end else begin
        held[free_slot] = 1'b1;
        held_key[free_slot] = key;
        held_tag[free_slot] = tag;
        held_count[free_slot] = init;
        held_total++;
      end
    end else if (hit < 0) begin
      r.status = ST_MISS;
    end else if (op == OP_WATCH) begin
      if (held_count[hit] != COUNT_MAX) begin
        held_count[hit] = held_count[hit] + 1'b1;
      end
      r.count = held_count[hit];
      r.tag = held_tag[hit];
    end else if (op == OP_REMOVE) begin
      held[hit] = 1'b0;
      if (held_total > 0) begin
        held_total--;
      end
    end else begin
      r.count = held_count[hit];
      r.tag = held_tag[hit];
    end
    r.entries = ent_t'(held_total);
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (!rst_n) begin
      held = '{default: 1'b0};
      held_total = 0;
      expected_replies.delete();
    end else begin
      // A result always belongs to an earlier request, so it is checked first.
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.count = rsp.count_out;
        got.tag = rsp.tag_out;
        got.entries = rsp.entries;
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: status %0d count %0d tag %h entries %0d",
                     got.status, got.count, got.tag, got.entries);
          end
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected status %0d count %0d tag %h entries %0d",
                       want.status, want.count, want.tag, want.entries);
              $display("                 got      status %0d count %0d tag %h entries %0d",
                       got.status, got.count, got.tag, got.entries);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_replies.push_back(apply_request(req.func, req.key, req.payload_tag,
                                                 req.initial_count));
      end
    end
    pending = expected_replies.size();
  end

endmodule

FILE: tb/keyed_counter_hash_table_test.sv
// ----------------------------------------------------------------------------
// keyed_counter_hash_table_test
// Drives the hash table with a directed set of requests covering misses,
// duplicates, full buckets, way reuse and count saturation, then with random
// requests on small pools of colliding keys, a fill of every bucket and a
// drain. Both channels idle at random; the checker gives the verdict data.
// ----------------------------------------------------------------------------
module keyed_counter_hash_table_test;
  import khash_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   idle_on;
  int   stall_left;
  key_t hot_keys[$];
  key_t fill_base[5];

  khash_req_if req_ch ();
  khash_rsp_if rsp_ch ();

  keyed_counter_hash_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  keyed_counter_hash_table_checker table_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic key_t key_in_bucket(key_t seed, int bucket);
    return seed - (seed % BUCKETS) + key_t'(bucket);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(func_t op, key_t key, tag_t tag, cnt_t init);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= op;
    req_ch.key <= key;
    req_ch.payload_tag <= tag;
    req_ch.initial_count <= init;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic new_hot_keys();
    int b;
    int a;
    int bucket;
    hot_keys.delete();
    for (b = 0; b < 8; b++) begin
      bucket = $urandom_range(0, BUCKETS - 1);
      for (a = 0; a < 6; a++) begin
        hot_keys.push_back(key_in_bucket($urandom(), bucket));
      end
    end
  endtask

  task automatic random_request();
    int    pick;
    func_t op;
    key_t  key;
    cnt_t  init;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_INSERT;
    end else if (pick < 65) begin
      op = OP_WATCH;
    end else if (pick < 80) begin
      op = OP_REMOVE;
    end else begin
      op = OP_LOOKUP;
    end
    if ($urandom_range(0, 9) == 0) begin
      key = $urandom();
    end else begin
      key = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
    end
    case ($urandom_range(0, 3))
      0: begin
        init = COUNT_MAX;
      end
      1: begin
        init = COUNT_MAX - 1'b1;
      end
      default: begin
        init = cnt_t'($urandom_range(0, 65535));
      end
    endcase
    send_request(op, key, $urandom(), init);
  endtask

  initial begin
    int phase;
    int n;
    int b;
    int a;
    int wait_cycles;
    req_ch.valid = 1'b0;
    req_ch.func = OP_INSERT;
    req_ch.key = '0;
    req_ch.payload_tag = '0;
    req_ch.initial_count = '0;
    rst_n = 1'b0;
    idle_on = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_WATCH, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_INSERT, '0, '0, '0);
    send_request(OP_INSERT, '0, '1, '1);
    send_request(OP_INSERT, '1, '1, COUNT_MAX);
    send_request(OP_WATCH, '1, '0, '0);
    send_request(OP_INSERT, key_t'(BUCKETS), 32'h5A5A_A5A5, COUNT_MAX - 1'b1);
    send_request(OP_INSERT, key_t'(2 * BUCKETS), 32'h1234_5678, 16'h00FF);
    send_request(OP_INSERT, key_t'(3 * BUCKETS), $urandom(), 16'h8000);
    send_request(OP_INSERT, key_t'(4 * BUCKETS), $urandom(), 16'h0001);
    send_request(OP_WATCH, key_t'(BUCKETS), '0, '0);
    send_request(OP_WATCH, key_t'(BUCKETS), '0, '0);
    send_request(OP_REMOVE, key_t'(BUCKETS), '0, '0);
    send_request(OP_LOOKUP, key_t'(BUCKETS), '0, '0);
    send_request(OP_INSERT, key_t'(5 * BUCKETS), 32'hDEAD_BEEF, 16'h7FFF);
    send_request(OP_LOOKUP, key_t'(5 * BUCKETS), '0, '0);
    send_request(OP_WATCH, '0, '1, '1);
    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_LOOKUP, '1, '0, '0);
    send_request(OP_REMOVE, '1, '0, '0);
    send_request(OP_WATCH, '1, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      idle_on = (phase % 2 == 0);
      new_hot_keys();
      for (n = 0; n < 130; n++) begin
        random_request();
      end
    end

    // Five fresh keys per bucket fill every bucket, whatever it held before.
    idle_on = 1'b1;
    for (a = 0; a < 5; a++) begin
      fill_base[a] = $urandom();
    end
    for (b = 0; b < BUCKETS; b++) begin
      for (a = 0; a < 5; a++) begin
        send_request(OP_INSERT, key_in_bucket(fill_base[a], b), $urandom(),
                     cnt_t'($urandom_range(0, 65535)));
      end
    end

    idle_on = 1'b0;
    for (b = BUCKETS - 1; b >= 0; b--) begin
      for (a = 0; a < 5; a++) begin
        send_request(OP_REMOVE, key_in_bucket(fill_base[a], b), $urandom(), '0);
      end
    end

    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
